// ===== design/hashed_set_assoc_age_cache_tags_defines.svh =====
// assertion macros shared by the checker
`ifndef HASHED_SET_ASSOC_AGE_CACHE_TAGS_DEFINES_SVH
`define HASHED_SET_ASSOC_AGE_CACHE_TAGS_DEFINES_SVH

// same-cycle implication
`define HSAC_ASSERT_SAME(lbl, clk, rst_n, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error(msg);

// next-cycle implication
`define HSAC_ASSERT_NEXT(lbl, clk, rst_n, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error(msg);

`endif

// ===== design/hsac_pkg.sv =====
package hsac_pkg;

  localparam int ADDR_W     = 48;
  localparam int DIR_W      = 5;
  localparam int TID_W      = 2;
  localparam int SLOT_IDX_W = 6;
  localparam int VIEW_W     = 3;

  localparam int THREADS_DEF  = 4;
  localparam int SLOTS_DEF    = 64;
  localparam int WAYS_DEF     = 4;
  localparam int AGE_BITS_DEF = 16;

  localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam int HASH_ADDR_LSB  = 6;
  localparam int HASH_ADDR_BITS = 28;
  localparam int HASH_DIR_BITS  = 4;

  typedef enum logic {
    ACT_LOOKUP     = 1'b0,
    ACT_INVALIDATE = 1'b1
  } action_e;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  typedef struct packed {
    logic capture;
    logic hold;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

  // bit-serial crc32c of one word, flattens to an xor network
  function automatic logic [31:0] crc32c_word(logic [31:0] crc, logic [31:0] v);
    logic [31:0] c;
    c = crc ^ v;
    for (int b = 0; b < 32; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [31:0] set_hash(logic [ADDR_W-1:0] addr, logic [DIR_W-1:0] dir);
    logic [31:0] key;
    key = {dir[HASH_DIR_BITS-1:0], addr[HASH_ADDR_LSB +: HASH_ADDR_BITS]};
    return crc32c_word(CRC_INIT, key);
  endfunction

endpackage

// ===== design/hsac_if.sv =====
interface hsac_req_if import hsac_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [TID_W-1:0]         thread_id;
  logic [ADDR_W-1:0]        cell_address;
  logic signed [DIR_W-1:0]  sort_dir;

  modport source (
    output valid, action, thread_id, cell_address, sort_dir,
    input  ready
  );
  modport sink (
    input  valid, action, thread_id, cell_address, sort_dir,
    output ready
  );
endinterface

interface hsac_rsp_if import hsac_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [SLOT_IDX_W-1:0] slot_index;
  logic [VIEW_W-1:0]     view_index;

  modport source (
    output valid, hit, slot_index, view_index,
    input  ready
  );
  modport sink (
    input  valid, hit, slot_index, view_index,
    output ready
  );
endinterface

// ===== design/hsac_ram.sv =====
module hsac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/hsac_ctrl.sv =====
module hsac_ctrl import hsac_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd_o.hold = 1'b1;
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/hsac_dp.sv =====
module hsac_dp import hsac_pkg::*; #(
  parameter int THREADS  = THREADS_DEF,
  parameter int SLOTS    = SLOTS_DEF,
  parameter int WAYS     = WAYS_DEF,
  parameter int AGE_BITS = AGE_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  output stat_t                   stat_o,
  input  logic                    action_i,
  input  logic [TID_W-1:0]        thread_id_i,
  input  logic [ADDR_W-1:0]       cell_address_i,
  input  logic signed [DIR_W-1:0] sort_dir_i,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic                    hit_o,
  output logic [SLOT_IDX_W-1:0]   slot_index_o,
  output logic [VIEW_W-1:0]       view_index_o
);

  localparam int SETS     = SLOTS / WAYS;
  localparam int ROWS     = THREADS * SETS;
  localparam int WAY_BITS = $clog2(WAYS);
  localparam int SET_W    = SETS > 1 ? $clog2(SETS) : 1;
  localparam int TW       = THREADS > 1 ? $clog2(THREADS) : 1;
  localparam int RW       = ROWS > 1 ? $clog2(ROWS) : 1;
  localparam int EW       = ADDR_W + DIR_W + AGE_BITS;
  localparam int ROW_W    = WAYS * EW;
  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

  function automatic logic [TW-1:0] fold_thread(logic [TID_W-1:0] tid);
    int t;
    t = int'(tid);
    for (int k = 0; k < (1 << TID_W) - 1; k++) begin
      if (t >= THREADS) t = t - THREADS;
    end
    return TW'(t);
  endfunction

  // captured item
  action_e           action_q;
  logic [TW-1:0]     thread_q;
  logic [SET_W-1:0]  set_q;
  logic [ADDR_W-1:0] addr_q;
  logic [DIR_W-1:0]  dir_q;

  logic [TW-1:0]     in_thread;
  logic [SET_W-1:0]  in_set;
  logic [RW-1:0]     in_row, row_q, rd_row;

  logic [ROW_W-1:0]  rd_data, wr_data;
  logic              ram_we;

  logic [WAYS-1:0]   valid_q [ROWS];
  logic [THREADS-1:0] toggle_q;

  logic [AGE_BITS-1:0] age_eff [WAYS];
  logic [WAYS-1:0]     match;
  logic                hit_c;
  logic [WAY_BITS-1:0] hit_way, vic_way, chosen;
  logic [AGE_BITS-1:0] top_age;
  logic                bump;

  logic                out_valid_q, hit_q;
  logic [SLOT_IDX_W-1:0] slot_q;
  logic [VIEW_W-1:0]   view_q;

  assign in_thread = fold_thread(thread_id_i);
  assign in_set    = SET_W'((set_hash(cell_address_i, sort_dir_i) >> WAY_BITS) % SETS);
  assign in_row    = RW'(int'(in_thread) * SETS + int'(in_set));
  assign row_q     = RW'(int'(thread_q) * SETS + int'(set_q));
  assign rd_row    = cmd_i.hold ? row_q : in_row;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      action_q <= action_e'(action_i);
      thread_q <= in_thread;
      set_q    <= in_set;
      addr_q   <= cell_address_i;
      dir_q    <= sort_dir_i;
    end
  end

  hsac_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (row_q),
    .wdata_i (wr_data),
    .raddr_i (rd_row),
    .rdata_o (rd_data)
  );

  // compare, victim choice and age update on the row just read
  always_comb begin
    hit_c    = 1'b0;
    hit_way  = '0;
    vic_way  = '0;
    for (int w = 0; w < WAYS; w++) begin
      age_eff[w] = valid_q[row_q][w] ? rd_data[w*EW + ADDR_W + DIR_W +: AGE_BITS] : AGE_MAX;
      match[w]   = valid_q[row_q][w]
                   && (rd_data[w*EW +: ADDR_W] == addr_q)
                   && (rd_data[w*EW + ADDR_W +: DIR_W] == dir_q);
    end
    for (int w = 0; w < WAYS; w++) begin
      if (!hit_c && match[w]) begin
        hit_c   = 1'b1;
        hit_way = WAY_BITS'(w);
      end
    end
    top_age = age_eff[0];
    for (int w = 1; w < WAYS; w++) begin
      if (age_eff[w] > top_age) begin
        top_age = age_eff[w];
        vic_way = WAY_BITS'(w);
      end
    end
    chosen = hit_c ? hit_way : vic_way;
    bump   = age_eff[chosen] != '0;
    for (int w = 0; w < WAYS; w++) begin
      wr_data[w*EW +: ADDR_W]        = rd_data[w*EW +: ADDR_W];
      wr_data[w*EW + ADDR_W +: DIR_W] = rd_data[w*EW + ADDR_W +: DIR_W];
      wr_data[w*EW + ADDR_W + DIR_W +: AGE_BITS] = age_eff[w];
      if (bump) begin
        if (age_eff[w] != AGE_MAX) begin
          wr_data[w*EW + ADDR_W + DIR_W +: AGE_BITS] = age_eff[w] + AGE_BITS'(1);
        end
        if (WAY_BITS'(w) == chosen) begin
          wr_data[w*EW + ADDR_W + DIR_W +: AGE_BITS] = '0;
        end
      end
      if (!hit_c && (WAY_BITS'(w) == chosen)) begin
        wr_data[w*EW +: ADDR_W]         = addr_q;
        wr_data[w*EW + ADDR_W +: DIR_W] = dir_q;
      end
    end
  end

  assign ram_we = cmd_i.commit && (action_q == ACT_LOOKUP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) begin
        valid_q[r] <= '0;
      end
      toggle_q <= '0;
    end else if (cmd_i.commit) begin
      if (action_q == ACT_INVALIDATE) begin
        for (int r = 0; r < ROWS; r++) begin
          valid_q[r] <= '0;
        end
      end else begin
        if (!hit_c) begin
          valid_q[row_q][chosen] <= 1'b1;
        end
        toggle_q[thread_q] <= ~toggle_q[thread_q];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (action_q == ACT_INVALIDATE) begin
        hit_q  <= 1'b0;
        slot_q <= '0;
        view_q <= '0;
      end else begin
        hit_q  <= hit_c;
        slot_q <= SLOT_IDX_W'((int'(set_q) << WAY_BITS) + int'(chosen));
        view_q <= VIEW_W'(2 * int'(thread_q) + int'(toggle_q[thread_q]));
      end
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign slot_index_o    = slot_q;
  assign view_index_o    = view_q;

endmodule

// ===== design/hashed_set_assoc_age_cache_tags.sv =====
// Per-thread set-associative tag store with age-based replacement.
// req_i carries one transfer per item: action (lookup or invalidate all),
// thread_id, cell_address and sort_dir. rsp_o returns one transfer per item:
// hit, slot_index and view_index (invalidate answers with all zeros).
// A result is loaded into the output register when the lookup state commits,
// once rsp_o is free. A new item is taken only after the last one commits,
// set by the read then write-back of a set row in the single-port-pair tag RAM;
// only one item is in flight, so a set may be looked up again straight away.
// Reset clears the per-slot valid bits and the per-thread view bits at once;
// slots not valid read as maximum age, so there is no clearing pass and an
// item can be taken in the first cycle after reset.
// When the receiver stalls the result is held in the output register; the
// next request is still taken, and its update waits in the lookup state
// until the output register frees, holding req_i off meanwhile.
module hashed_set_assoc_age_cache_tags import hsac_pkg::*; #(
  parameter int THREADS  = THREADS_DEF,
  parameter int SLOTS    = SLOTS_DEF,
  parameter int WAYS     = WAYS_DEF,
  parameter int AGE_BITS = AGE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hsac_req_if.sink    req_i,
  hsac_rsp_if.source  rsp_o
);

  cmd_t  cmd;
  stat_t stat;

  hsac_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  hsac_dp #(
    .THREADS  (THREADS),
    .SLOTS    (SLOTS),
    .WAYS     (WAYS),
    .AGE_BITS (AGE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .action_i       (req_i.action),
    .thread_id_i    (req_i.thread_id),
    .cell_address_i (req_i.cell_address),
    .sort_dir_i     (req_i.sort_dir),
    .out_ready_i    (rsp_o.ready),
    .out_valid_o    (rsp_o.valid),
    .hit_o          (rsp_o.hit),
    .slot_index_o   (rsp_o.slot_index),
    .view_index_o   (rsp_o.view_index)
  );

endmodule

// ===== design/hsac_checker.sv =====
`include "hashed_set_assoc_age_cache_tags_defines.svh"

module hsac_checker import hsac_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  req_valid_i,
  input logic                  req_ready_i,
  input logic                  req_action_i,
  input logic                  rsp_valid_i,
  input logic                  rsp_ready_i,
  input logic                  rsp_hit_i,
  input logic [SLOT_IDX_W-1:0] rsp_slot_index_i,
  input logic [VIEW_W-1:0]     rsp_view_index_i
);

  `HSAC_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i, "request taken while busy")

  `HSAC_ASSERT_NEXT(a_result_due, clk_i, rst_ni, $past(rst_ni) && $past(req_valid_i && req_ready_i) && (!rsp_valid_i || rsp_ready_i), rsp_valid_i, "result missing after free output")

  `HSAC_ASSERT_NEXT(a_invalidate_zero, clk_i, rst_ni, $past(rst_ni) && $past(req_valid_i && req_ready_i && (req_action_i == ACT_INVALIDATE)) && (!rsp_valid_i || rsp_ready_i), rsp_valid_i && !rsp_hit_i && (rsp_slot_index_i == '0) && (rsp_view_index_i == '0), "invalidate result not zero")

  `HSAC_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_hit_i) && $stable(rsp_slot_index_i) && $stable(rsp_view_index_i), "stalled result changed")

endmodule

bind hashed_set_assoc_age_cache_tags hsac_checker u_hsac_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .req_action_i     (req_i.action),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_hit_i        (rsp_o.hit),
  .rsp_slot_index_i (rsp_o.slot_index),
  .rsp_view_index_i (rsp_o.view_index)
);
